// ----- rtl/core/lkvc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared sizes, codes, state type and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   // Built store depth and the number of key bits that take part in a match.
   localparam int LKV_DEPTH    = 16;
   localparam int LKV_KEY_BITS = 16;

   // Field widths fixed by the channel formats.
   localparam int KEY_W      = 16;
   localparam int VAL_W      = 32;
   localparam int CAP_W      = 5;
   localparam int ADDR_W     = 3;
   localparam int CSR_DATA_W = 32;

   localparam int IDX_W = (LKV_DEPTH > 1) ? $clog2(LKV_DEPTH) : 1;
   localparam int OCC_W = $clog2(LKV_DEPTH + 1);
   localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   localparam logic [KEY_W-1:0] KEY_MASK =
      (LKV_KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((1 << LKV_KEY_BITS) - 1);

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // Register index, taken from the word address.
   localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;

   // Operation codes.
   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   localparam logic signed [VAL_W-1:0] MISS_VALUE = -1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } lkvc_state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic finish;
   } lkvc_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } lkvc_sts_type;

endpackage

// ----- rtl/core/lkvc_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache channel interfaces
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lkvc_req_if import lkvc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    mode;
   logic [KEY_W-1:0]        key;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, output mode, output key, output value, input ready);
   modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    hit;
   logic signed [VAL_W-1:0] read_value;
   logic                    evicted;
   logic [KEY_W-1:0]        evicted_key;

   modport source (output valid, output hit, output read_value, output evicted,
                   output evicted_key, input ready);
   modport sink   (input valid, input hit, input read_value, input evicted,
                   input evicted_key, output ready);
endinterface

// ----- rtl/core/lkvc_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache register block
// APB-style register port holding the capacity register.
// ----------------------------------------------------------------------------
module lkvc_csr import lkvc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [CAP_W-1:0]      capacity
);

   logic [CAP_W-1:0]  capacity_ff;
   logic [CAP_W-1:0]  capacity_in;
   logic [ADDR_W-3:0] reg_index;
   logic              wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[ADDR_W-1:2];
   assign wr_en     = psel && penable && pwrite && pready;

   always_comb begin
      capacity_in = capacity_ff;
      if (wr_en && reg_index == REG_CAPACITY) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign prdata   = (reg_index == REG_CAPACITY) ? CSR_DATA_W'(capacity_ff) : '0;
   assign capacity = capacity_ff;

endmodule

// ----- rtl/core/lkvc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache controller
// Sequences accept, entry scan and table update for one request at a time.
// ----------------------------------------------------------------------------
module lkvc_ctrl import lkvc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  lkvc_sts_type sts,
   output lkvc_cmd_type cmd
);

   lkvc_state_type state_ff;
   lkvc_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // The update and the result load happen together, so wait for room.
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/lkvc_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache datapath
// Key and value stores, valid bits, recency ranks, the serial entry scan and
// the result register.
// ----------------------------------------------------------------------------
module lkvc_dpath import lkvc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  lkvc_cmd_type            cmd,
   output lkvc_sts_type            sts,
   input  logic [CAP_W-1:0]        capacity,
   input  logic                    req_mode,
   input  logic [KEY_W-1:0]        req_key,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic                    rsp_hit,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic                    rsp_evicted,
   output logic [KEY_W-1:0]        rsp_evicted_key
);

   // Stores
   logic [KEY_W-1:0]        key_mem [LKV_DEPTH];
   logic signed [VAL_W-1:0] val_mem [LKV_DEPTH];
   logic [LKV_DEPTH-1:0]    valid_ff, valid_in;
   logic [IDX_W-1:0]        rank_ff [LKV_DEPTH];
   logic [IDX_W-1:0]        rank_in [LKV_DEPTH];
   logic [OCC_W-1:0]        occ_ff, occ_in;

   // Latched request
   logic                    mode_ff;
   logic [KEY_W-1:0]        key_ff;
   logic signed [VAL_W-1:0] value_ff;

   // Scan pipeline
   logic [OCC_W-1:0]        cnt_ff;
   logic                    cmp_vld_ff;
   logic [IDX_W-1:0]        cmp_idx_ff;
   logic [KEY_W-1:0]        rd_key_ff;
   logic signed [VAL_W-1:0] rd_val_ff;

   // Scan results
   logic                    found_ff, free_ff, lru_ff;
   logic [IDX_W-1:0]        found_idx_ff, free_idx_ff, lru_idx_ff;
   logic [IDX_W-1:0]        found_rank_ff, lru_rank_ff;
   logic signed [VAL_W-1:0] found_val_ff;
   logic [KEY_W-1:0]        lru_key_ff;

   // Result register
   logic                    rsp_valid_ff;
   logic                    rsp_hit_ff;
   logic signed [VAL_W-1:0] rsp_read_value_ff;
   logic                    rsp_evicted_ff;
   logic [KEY_W-1:0]        rsp_evicted_key_ff;

   logic             issue;
   logic [IDX_W-1:0] scan_addr;
   logic             ent_valid;
   logic [IDX_W-1:0] ent_rank;
   logic             take_found, take_free, take_lru;
   logic [CMP_W-1:0] cap_ext, usable;
   logic             has_room, put_miss, do_evict;
   logic [IDX_W-1:0] wr_idx;
   logic             key_we, val_we;

   assign issue     = cmd.scan && (cnt_ff < OCC_W'(LKV_DEPTH));
   assign scan_addr = cnt_ff[IDX_W-1:0];

   assign ent_valid  = valid_ff[cmp_idx_ff];
   assign ent_rank   = rank_ff[cmp_idx_ff];
   assign take_found = cmp_vld_ff && ent_valid && (rd_key_ff == key_ff) && !found_ff;
   assign take_free  = cmp_vld_ff && !ent_valid && !free_ff;
   assign take_lru   = cmp_vld_ff && ent_valid && (!lru_ff || ent_rank > lru_rank_ff);

   // Capacity zero behaves as one, and anything above the store depth saturates.
   assign cap_ext = CMP_W'(capacity);
   always_comb begin
      if (cap_ext == '0) begin
         usable = CMP_W'(1);
      end else if (cap_ext > CMP_W'(LKV_DEPTH)) begin
         usable = CMP_W'(LKV_DEPTH);
      end else begin
         usable = cap_ext;
      end
   end

   assign has_room = (CMP_W'(occ_ff) < usable) && free_ff;
   assign put_miss = (mode_ff == MODE_PUT) && !found_ff;
   assign do_evict = put_miss && !has_room && lru_ff;

   always_comb begin
      priority if (found_ff) begin
         wr_idx = found_idx_ff;
      end else if (has_room) begin
         wr_idx = free_idx_ff;
      end else if (lru_ff) begin
         wr_idx = lru_idx_ff;
      end else begin
         wr_idx = '0;
      end
   end

   assign key_we = cmd.finish && put_miss;
   assign val_we = cmd.finish && (mode_ff == MODE_PUT);

   // Recency and occupancy update, applied in the finishing cycle.
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < LKV_DEPTH; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (cmd.finish) begin
         if (found_ff) begin
            for (int i = 0; i < LKV_DEPTH; i++) begin
               if (valid_ff[i] && IDX_W'(i) != found_idx_ff && rank_ff[i] < found_rank_ff) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
            rank_in[found_idx_ff] = '0;
         end else if (put_miss) begin
            // An evicted entry is the written slot itself, so it is skipped here.
            for (int i = 0; i < LKV_DEPTH; i++) begin
               if (valid_ff[i] && IDX_W'(i) != wr_idx) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
            rank_in[wr_idx]  = '0;
            valid_in[wr_idx] = 1'b1;
            if (!do_evict) begin
               occ_in = occ_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_key_ff <= key_mem[scan_addr];
         rd_val_ff <= val_mem[scan_addr];
      end
      if (key_we) begin
         key_mem[wr_idx] <= key_ff;
      end
      if (val_we) begin
         val_mem[wr_idx] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         occ_ff       <= '0;
         cnt_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         lru_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LKV_DEPTH; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff   <= valid_in;
         occ_ff     <= occ_in;
         cmp_vld_ff <= issue;
         for (int i = 0; i < LKV_DEPTH; i++) begin
            rank_ff[i] <= rank_in[i];
         end
         if (cmd.start) begin
            cnt_ff   <= '0;
            found_ff <= 1'b0;
            free_ff  <= 1'b0;
            lru_ff   <= 1'b0;
         end else begin
            if (issue) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            if (take_found) begin
               found_ff <= 1'b1;
            end
            if (take_free) begin
               free_ff <= 1'b1;
            end
            if (take_lru) begin
               lru_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= scan_addr;
      if (cmd.start) begin
         mode_ff  <= req_mode;
         key_ff   <= req_key & KEY_MASK;
         value_ff <= req_value;
      end
      if (take_found) begin
         found_idx_ff  <= cmp_idx_ff;
         found_rank_ff <= ent_rank;
         found_val_ff  <= rd_val_ff;
      end
      if (take_free) begin
         free_idx_ff <= cmp_idx_ff;
      end
      if (take_lru) begin
         lru_idx_ff  <= cmp_idx_ff;
         lru_rank_ff <= ent_rank;
         lru_key_ff  <= rd_key_ff;
      end
      if (cmd.finish) begin
         rsp_hit_ff <= found_ff;
         if (mode_ff == MODE_GET) begin
            rsp_read_value_ff <= found_ff ? found_val_ff : MISS_VALUE;
         end else begin
            rsp_read_value_ff <= '0;
         end
         rsp_evicted_ff     <= do_evict;
         rsp_evicted_key_ff <= do_evict ? lru_key_ff : '0;
      end
   end

   assign sts.scan_done = cmp_vld_ff && (cmp_idx_ff == IDX_W'(LKV_DEPTH - 1));
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

endmodule

// ----- rtl/core/lru_key_value_cache_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache top level
// Fully associative 16-entry key/value store with least-recently-used
// replacement.
//
// A request beat on req_ch carries mode (get or put), key and value. Every
// request yields exactly one response beat on rsp_ch with hit, read_value,
// evicted and evicted_key. A get miss returns -1; a put always returns 0 and
// reports the victim key when a miss forced an eviction.
// Each request is accepted in the idle state and then scanned: one key and value
// memory read per entry, each entry compared in the cycle after its read, then a
// single update step. The next request is accepted on the cycle after the update,
// so only one request is in progress at a time.
// The response sits in an output register; while it waits for rsp_ch.ready the
// next request is still accepted and scanned, and only its update stalls.
// Synchronous reset empties the store (all entries invalid, occupancy zero)
// and sets the capacity register to 16. Capacity is written over the csr_
// port at byte address 0 and must only be changed while the cache is idle.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top import lkvc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lkvc_req_if.sink              req_ch,
   lkvc_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   lkvc_cmd_type     cmd;
   lkvc_sts_type     sts;
   logic [CAP_W-1:0] capacity;

   lkvc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (csr_psel),
      .penable  (csr_penable),
      .pwrite   (csr_pwrite),
      .paddr    (csr_paddr),
      .pwdata   (csr_pwdata),
      .prdata   (csr_prdata),
      .pready   (csr_pready),
      .capacity (capacity)
   );

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lkvc_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .capacity        (capacity),
      .req_mode        (req_ch.mode),
      .req_key         (req_ch.key),
      .req_value       (req_ch.value),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_hit         (rsp_ch.hit),
      .rsp_read_value  (rsp_ch.read_value),
      .rsp_evicted     (rsp_ch.evicted),
      .rsp_evicted_key (rsp_ch.evicted_key)
   );

   // Every accepted beat starts a scan, and no second beat enters behind it.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> cmd.start)
      else $error("accepted request did not start a scan");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !req_ch.ready)
      else $error("request accepted while another is in progress");

   // The result register is only loaded when it is free, and then holds a beat.
   a_finish_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (sts.out_free ##1 rsp_ch.valid))
      else $error("result loaded over an unaccepted response");

   a_evict_is_put_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.evicted) |-> (!rsp_ch.hit && rsp_ch.read_value == '0))
      else $error("eviction reported on a response that is not a put miss");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get and put requests into the cache and checks every response beat
// against a shadow copy of the store kept in the bench. A short walk through
// a table of hand-picked requests and capacity writes comes first. Random
// phases follow, each one at its own capacity setting. Both channels idle at
// random, apart from one steady stretch. Once the response side holds off for
// long enough that the cache backs up and stalls its request channel.
// ----------------------------------------------------------------------------
module tb_top import lkvc_pkg::*; ();

   localparam int HOLD_AT_BEAT   = 150;
   localparam int HOLD_CYCLES    = 300;
   localparam int STEADY_FROM    = 320;
   localparam int STEADY_TO      = 400;
   localparam int PHASE_BEATS    = 60;
   localparam int NUM_PHASES     = 8;
   localparam int DRAIN_CYCLES   = 40;
   localparam int QUIET_LIMIT    = 2000;
   localparam int MAX_REPORTED   = 10;

   localparam logic [ADDR_W-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
   localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = {~REG_CAPACITY, 2'b00};

   typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] read_value;
      logic             evicted;
      logic [KEY_W-1:0] evicted_key;
   } lookup_result_type;

   typedef enum bit {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [ADDR_W-1:0] addr;
      logic [31:0]       wdata;
      logic              mode;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
      bit                typed;
      lookup_result_type want;
   } plan_row_type;

   logic clock;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [ADDR_W-1:0]     csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   lkvc_req_if req_if ();
   lkvc_rsp_if rsp_if ();

   lru_key_value_cache_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow of the store, the recency order and the capacity register.
   logic [KEY_W-1:0] shadow_key   [LKV_DEPTH];
   logic [VAL_W-1:0] shadow_value [LKV_DEPTH];
   bit               shadow_valid [LKV_DEPTH];
   int unsigned      shadow_rank  [LKV_DEPTH];
   int unsigned      shadow_occupancy;
   logic [CAP_W-1:0] shadow_capacity;

   lookup_result_type outstanding_lookups[$];
   plan_row_type      directed_plan[$];

   int  beats_in;
   int  mismatches;
   int  quiet_cycles;
   bit  steady;
   bit  held_off;

   function automatic int usable_capacity(input logic [CAP_W-1:0] cap);
      if (cap == 0)
         return 1;
      if (cap > LKV_DEPTH)
         return LKV_DEPTH;
      return int'(cap);
   endfunction

   function automatic lookup_result_type lru_apply(input logic m, input logic [KEY_W-1:0] k,
                                                   input logic [VAL_W-1:0] v);
      lookup_result_type r;
      int found;
      int slot;
      int unsigned worst;
      int unsigned old_rank;
      r = '0;
      found = -1;
      slot = -1;
      worst = 0;
      k = k & KEY_MASK;
      for (int i = 0; i < LKV_DEPTH; i++) begin
         if (found < 0 && shadow_valid[i] && shadow_key[i] == k)
            found = i;
      end
      if (found >= 0) begin
         r.hit = 1'b1;
         if (m == MODE_GET)
            r.read_value = shadow_value[found];
         else
            shadow_value[found] = v;
         old_rank = shadow_rank[found];
         for (int i = 0; i < LKV_DEPTH; i++) begin
            if (shadow_valid[i] && i != found && shadow_rank[i] < old_rank)
               shadow_rank[i]++;
         end
         shadow_rank[found] = 0;
      end else if (m == MODE_GET) begin
         r.read_value = MISS_VALUE;
      end else begin
         if (shadow_occupancy < usable_capacity(shadow_capacity)) begin
            for (int i = 0; i < LKV_DEPTH; i++) begin
               if (slot < 0 && !shadow_valid[i])
                  slot = i;
            end
         end
         if (slot < 0) begin
            // Victim is the first valid entry holding the highest rank.
            for (int i = 0; i < LKV_DEPTH; i++) begin
               if (shadow_valid[i] && (slot < 0 || shadow_rank[i] > worst)) begin
                  slot = i;
                  worst = shadow_rank[i];
               end
            end
            if (slot >= 0) begin
               r.evicted = 1'b1;
               r.evicted_key = shadow_key[slot];
               shadow_valid[slot] = 1'b0;
               shadow_occupancy--;
            end else begin
               slot = 0;
            end
         end
         for (int i = 0; i < LKV_DEPTH; i++) begin
            if (shadow_valid[i])
               shadow_rank[i]++;
         end
         shadow_key[slot] = k;
         shadow_value[slot] = v;
         shadow_valid[slot] = 1'b1;
         shadow_rank[slot] = 0;
         shadow_occupancy++;
      end
      return r;
   endfunction

   task automatic plan_beat(input logic m, input logic [KEY_W-1:0] k,
                            input logic [VAL_W-1:0] v);
      plan_row_type row;
      row = '{ROW_BEAT, '0, '0, m, k, v, 1'b0, '0};
      directed_plan.insert(directed_plan.size(), row);
   endtask

   task automatic plan_typed(input logic m, input logic [KEY_W-1:0] k,
                             input logic [VAL_W-1:0] v, input lookup_result_type w);
      plan_row_type row;
      row = '{ROW_BEAT, '0, '0, m, k, v, 1'b1, w};
      directed_plan.insert(directed_plan.size(), row);
   endtask

   task automatic plan_csr(input logic [ADDR_W-1:0] a, input logic [31:0] d);
      plan_row_type row;
      row = '{ROW_CSR, a, d, MODE_GET, '0, '0, 1'b0, '0};
      directed_plan.insert(directed_plan.size(), row);
   endtask

   // Offers one request beat; the expectation is queued once it is taken.
   task automatic send_request(input logic m, input logic [KEY_W-1:0] k,
                               input logic [VAL_W-1:0] v, input bit typed,
                               input lookup_result_type want);
      lookup_result_type predicted;
      while (!steady && $urandom_range(99) < 30) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.mode  <= m;
      req_if.key   <= k;
      req_if.value <= v;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      predicted = lru_apply(m, k, v);
      outstanding_lookups.insert(outstanding_lookups.size(), typed ? want : predicted);
      beats_in++;
      steady = (beats_in >= STEADY_FROM && beats_in < STEADY_TO);
   endtask

   // Capacity is only touched once every response is back and the cache is idle.
   task automatic write_register(input logic [ADDR_W-1:0] a, input logic [31:0] d);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding_lookups.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= a;
      csr_pwdata  <= d;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (a[ADDR_W-1:2] == REG_CAPACITY)
         shadow_capacity = d[CAP_W-1:0];
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Response side: random back-pressure plus one long hold-off.
   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         @(posedge clock);
         if (!held_off && beats_in >= HOLD_AT_BEAT) begin
            held_off = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_if.ready <= steady || ($urandom_range(99) >= 30);
      end
   end

   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (outstanding_lookups.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED)
               $display("response beat with nothing outstanding: hit=%0d val=%h",
                        rsp_if.hit, rsp_if.read_value,
                        " ev=%0d key=%h", rsp_if.evicted, rsp_if.evicted_key);
         end else begin
            want = outstanding_lookups.pop_front();
            if (rsp_if.hit !== want.hit || rsp_if.read_value !== want.read_value ||
                rsp_if.evicted !== want.evicted || rsp_if.evicted_key !== want.evicted_key) begin
               mismatches++;
               if (mismatches <= MAX_REPORTED)
                  $display("mismatch: exp hit=%0d val=%h ev=%0d key=%h,",
                           want.hit, want.read_value, want.evicted, want.evicted_key,
                           " got hit=%0d val=%h ev=%0d key=%h",
                           rsp_if.hit, rsp_if.read_value, rsp_if.evicted,
                           rsp_if.evicted_key);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                   (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      plan_row_type     row;
      logic [CAP_W-1:0] cap;
      logic [KEY_W-1:0] key_pool[$];
      int               pool_size;
      logic [KEY_W-1:0] k;
      logic             m;

      beats_in = 0;
      mismatches = 0;
      steady = 1'b0;
      held_off = 1'b0;
      for (int i = 0; i < LKV_DEPTH; i++) begin
         shadow_key[i] = '0;
         shadow_value[i] = '0;
         shadow_valid[i] = 1'b0;
         shadow_rank[i] = 0;
      end
      shadow_occupancy = 0;
      shadow_capacity = CAP_RESET;

      req_if.valid <= 1'b0;
      req_if.mode  <= MODE_GET;
      req_if.key   <= '0;
      req_if.value <= '0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;

      // Empty store, extreme keys and values, overwrite on a put hit.
      plan_typed(MODE_GET, 16'h0000, 32'h0000_0000, '{1'b0, MISS_VALUE, 1'b0, 16'h0000});
      plan_typed(MODE_PUT, 16'h0000, 32'h7FFF_FFFF, '0);
      plan_typed(MODE_GET, 16'h0000, 32'h0000_0000, '{1'b1, 32'h7FFF_FFFF, 1'b0, 16'h0000});
      plan_typed(MODE_PUT, 16'hFFFF, 32'h8000_0000, '0);
      plan_typed(MODE_GET, 16'hFFFF, 32'h1234_5678, '{1'b1, 32'h8000_0000, 1'b0, 16'h0000});
      plan_typed(MODE_PUT, 16'hFFFF, 32'hFFFF_FFFF, '{1'b1, 32'h0, 1'b0, 16'h0000});
      plan_typed(MODE_GET, 16'hFFFF, 32'h0000_0000, '{1'b1, 32'hFFFF_FFFF, 1'b0, 16'h0000});
      plan_beat(MODE_GET, 16'h1234, 32'hDEAD_BEEF);
      // Capacity dropped below occupancy: each put miss swaps out one entry.
      plan_csr(ADDR_CAPACITY, 32'd1);
      plan_typed(MODE_PUT, 16'h1234, 32'd5, '{1'b0, 32'h0, 1'b1, 16'h0000});
      plan_typed(MODE_PUT, 16'h5678, 32'd6, '{1'b0, 32'h0, 1'b1, 16'hFFFF});
      plan_beat(MODE_PUT, 16'h9ABC, 32'd7);
      plan_beat(MODE_GET, 16'h5678, 32'd0);
      // A capacity of zero behaves as one.
      plan_csr(ADDR_CAPACITY, 32'd0);
      plan_beat(MODE_PUT, 16'h0001, 32'd1);
      plan_beat(MODE_GET, 16'h9ABC, 32'd0);
      // Writes to an unmapped address leave the capacity alone.
      plan_csr(ADDR_UNMAPPED, 32'd3);
      plan_beat(MODE_PUT, 16'h0002, 32'd2);
      // Anything above the built depth saturates to it.
      plan_csr(ADDR_CAPACITY, 32'd31);
      plan_beat(MODE_PUT, 16'h0003, 32'd3);
      plan_beat(MODE_PUT, 16'h0004, 32'h5555_5555);
      plan_beat(MODE_GET, 16'h0002, 32'd0);
      plan_beat(MODE_PUT, 16'h0002, 32'hAAAA_AAAA);
      plan_beat(MODE_GET, 16'h0003, 32'd0);
      plan_csr(ADDR_CAPACITY, 32'd2);
      plan_beat(MODE_PUT, 16'h0005, 32'd5);
      plan_beat(MODE_PUT, 16'h0006, 32'd6);
      plan_beat(MODE_GET, 16'h0005, 32'd0);

      @(posedge clock);
      while (reset)
         @(posedge clock);

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.kind == ROW_CSR)
            write_register(row.addr, row.wdata);
         else
            send_request(row.mode, row.key, row.value, row.typed, row.want);
      end

      // Random phases; a small key pool per phase keeps hits and evictions frequent.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: cap = 5'd16;
            1: cap = 5'd1;
            2: cap = 5'd3;
            3: cap = 5'd0;
            4: cap = 5'd31;
            5: cap = 5'd8;
            6: cap = 5'(2 + $urandom_range(13));
            default: cap = CAP_RESET;
         endcase
         write_register(ADDR_CAPACITY, 32'(cap));
         key_pool.delete();
         pool_size = usable_capacity(cap) + $urandom_range(1, 4);
         for (int i = 0; i < pool_size; i++)
            key_pool.insert(key_pool.size(), KEY_W'($urandom));
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if ($urandom_range(99) < 85)
               k = key_pool[$urandom_range(pool_size - 1)];
            else
               k = KEY_W'($urandom);
            m = ($urandom_range(99) < 50) ? MODE_PUT : MODE_GET;
            send_request(m, k, VAL_W'($urandom), 1'b0, '0);
         end
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding_lookups.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding_lookups.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
